### hdl/md4_pkg.sv
// MD4 engine package: shared types, constants and step tables.
// No dependencies.
`default_nettype none
package md4_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BUF_DEPTH = 16;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_PAD, ST_LEN, ST_EMIT
  } md4_state_t;

  // word index used by each of the 48 steps
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] k;
    k = step[3:0];
    if (step < 6'd16) return k;
    else if (step < 6'd32) return {k[1:0], k[3:2]};
    else return {k[0], k[1], k[2], k[3]};
  endfunction

  function automatic logic [4:0] step_shift(input logic [5:0] step);
    logic [4:0] s;
    s = 5'd3;
    if (step < 6'd16) begin
      case (step[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd7;
        2'd2: s = 5'd11;
        default: s = 5'd19;
      endcase
    end else if (step < 6'd32) begin
      case (step[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd5;
        2'd2: s = 5'd9;
        default: s = 5'd13;
      endcase
    end else begin
      case (step[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd9;
        2'd2: s = 5'd11;
        default: s = 5'd15;
      endcase
    end
    return s;
  endfunction
endpackage
`default_nettype wire

### hdl/md4_if.sv
// Valid/ready channel interfaces for the MD4 engine.
// Depends on nothing.
`default_nettype none
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_message;
  modport source (output valid, data_byte, has_byte, end_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_message, output ready);
endinterface

interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### hdl/md4_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module md4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/md4_round.sv
// MD4 step unit: one combinational compression step on the rotating working set.
// Depends on md4_pkg.
`default_nettype none
module md4_round (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] m,
  input  wire logic [5:0]  step,
  output logic      [31:0] a_new
);
  import md4_pkg::*;
  logic [31:0] f, k, sum;
  logic [4:0]  s;
  logic [63:0] dbl;
  always_comb begin
    if (step < 6'd16) begin
      f = d ^ (b & (c ^ d));
      k = '0;
    end else if (step < 6'd32) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND2;
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND3;
    end
    s = step_shift(step);
    sum = a + f + m + k;
    dbl = {sum, sum} << s;
    a_new = dbl[63:32];
  end
endmodule
`default_nettype wire

### hdl/md4_hash_engine_top.sv
// MD4 hash engine top level: byte packing, padding sequencer, step unit.
// Depends on md4_pkg, md4_if, md4_ram, md4_round.
// Data byte: taken while idle; the 64th byte of a block then stalls input for a compression
// (48 steps, each a registered word read then a step; the chaining add lands with step 48).
// Finish: padding fills the remaining words one per cycle, then one or two
// compressions, then four output transfers. Reset restores the IV and clears the count.
`default_nettype none
module md4_hash_engine_top (
  input wire logic clk,
  input wire logic rst,
  md4_in_if.sink   in_ch,
  md4_out_if.source out_ch
);
  import md4_pkg::*;

  md4_state_t state, state_next;
  logic [31:0] cv [4];
  logic [31:0] v  [4];        // a,b,c,d working set (a rotates)
  logic [63:0] bit_count;
  logic [31:0] word_acc;      // word being packed
  logic [5:0]  step;
  logic        phase;         // 0: address issued, 1: data present
  logic        fin_pend;      // compress is part of a finish
  logic        second;        // second compression needed after this one
  logic [3:0]  pad_idx;
  logic [1:0]  emit_idx;

  // buffer RAM
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  md4_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [31:0] a_new;
  md4_round u_step (
    .a(v[0]), .b(v[1]), .c(v[2]), .d(v[3]), .m(rdata), .step(step), .a_new(a_new)
  );

  wire [5:0] pos = bit_count[8:3];
  wire       take = in_ch.valid && in_ch.ready;
  logic [31:0] packed_w;
  always_comb begin
    packed_w = word_acc;
    case (pos[1:0])
      2'd0: packed_w = {24'd0, in_ch.data_byte};
      2'd1: packed_w[15:8]  = in_ch.data_byte;
      2'd2: packed_w[23:16] = in_ch.data_byte;
      default: packed_w[31:24] = in_ch.data_byte;
    endcase
  end

  // pad word at index pad_idx; pos gives where the marker sits
  logic [31:0] pad_w;
  always_comb begin
    pad_w = '0;
    if (pad_idx == pos[5:2]) begin
      case (pos[1:0])
        2'd0: pad_w = {24'd0, PAD_MARK};
        2'd1: pad_w = {16'd0, PAD_MARK, word_acc[7:0]};
        2'd2: pad_w = {8'd0, PAD_MARK, word_acc[15:0]};
        default: pad_w = {PAD_MARK, word_acc[23:0]};
      endcase
    end
    if (!second) begin
      if (pad_idx == 4'd14) pad_w = bit_count[31:0];
      if (pad_idx == 4'd15) pad_w = bit_count[63:32];
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_EMIT);
  assign out_ch.digest_word = cv[emit_idx];
  assign out_ch.word_index = emit_idx;
  assign out_ch.last_word = (emit_idx == 2'd3);

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = pos[5:2];
    wdata = packed_w;
    raddr = msg_index(step);
    unique case (state)
      ST_IDLE: begin
        if (take && in_ch.has_byte) begin
          we = 1'b1;
          if (pos == 6'd63) state_next = ST_COMP;
          else if (in_ch.end_message) state_next = ST_PAD;
        end else if (take && in_ch.end_message) state_next = ST_PAD;
      end
      ST_PAD, ST_LEN: begin
        we = 1'b1;
        waddr = pad_idx;
        wdata = pad_w;
        if (pad_idx == 4'd15) state_next = ST_COMP;
      end
      ST_COMP: begin
        if (phase && step == 6'd47) begin
          if (second) state_next = ST_LEN;
          else if (fin_pend) state_next = ST_EMIT;
          else state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready && emit_idx == 2'd3) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= IV0; cv[1] <= IV1; cv[2] <= IV2; cv[3] <= IV3;
      bit_count <= '0;
      step <= '0; phase <= 1'b0; fin_pend <= 1'b0; second <= 1'b0;
      pad_idx <= '0; emit_idx <= '0; word_acc <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0; phase <= 1'b0; emit_idx <= '0;
          if (take) begin
            if (in_ch.has_byte) begin
              word_acc <= packed_w;
              bit_count <= bit_count + 64'd8;
            end
            fin_pend <= in_ch.end_message;
            // position after this byte
            pad_idx <= (in_ch.has_byte ? pos[5:2] + {3'd0, &pos[1:0]} : pos[5:2]);
            second <= 1'b0;
            if (in_ch.end_message) begin
              if (in_ch.has_byte ? (pos >= 6'd55) : (pos >= 6'd56)) second <= 1'b1;
            end
            v[0] <= cv[0]; v[1] <= cv[1]; v[2] <= cv[2]; v[3] <= cv[3];
          end
        end
        ST_PAD, ST_LEN: begin
          pad_idx <= pad_idx + 4'd1;
          step <= '0; phase <= 1'b0;
          v[0] <= cv[0]; v[1] <= cv[1]; v[2] <= cv[2]; v[3] <= cv[3];
        end
        ST_COMP: begin
          phase <= ~phase;
          if (phase) begin
            // rotate: new a goes to b position, d becomes a
            v[0] <= v[3]; v[1] <= a_new; v[2] <= v[1]; v[3] <= v[2];
            step <= step + 6'd1;
            if (step == 6'd47) begin
              cv[0] <= cv[0] + v[3];
              cv[1] <= cv[1] + a_new;
              cv[2] <= cv[2] + v[1];
              cv[3] <= cv[3] + v[2];
              if (second) begin
                second <= 1'b0;
                pad_idx <= '0;
                word_acc <= '0;
              end
            end
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              cv[0] <= IV0; cv[1] <= IV1; cv[2] <= IV2; cv[3] <= IV3;
              bit_count <= '0;
              fin_pend <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // In the second pad block the marker must not reappear after the first block held it.
  // Handled since pad_idx==pos[5:2] then only matches word 14 or 15, overwritten by count.

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_last_on_three: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_word) |-> (out_ch.word_index == 2'd3))
    else $error("last flag misplaced");
  a_emit_after_comp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_COMP) else $error("emit without compress");
endmodule
`default_nettype wire

### test/md4_tb_pkg.sv
// Scoreboard class for the MD4 engine testbench: digest predictor and expected-word store.
// Depends on md4_pkg.
`timescale 1ns / 1ps
package md4_tb_pkg;
  import md4_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_res_t;

  class md4_scoreboard;
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [63:0] nbits;
    digest_res_t pending [$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3;
      foreach (blk[i]) blk[i] = '0;
      nbits = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void compress();
      logic [31:0] v [4];
      logic [31:0] x, y, z, f, m;
      int w, s, k;
      int ord2 [16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};
      int ord3 [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
      int s1 [4] = '{3, 7, 11, 19};
      int s2 [4] = '{3, 5, 9, 13};
      int s3 [4] = '{3, 9, 11, 15};
      for (int i = 0; i < 4; i++) v[i] = chain[i];
      for (int i = 0; i < 48; i++) begin
        w = (4 - (i % 4)) % 4;
        x = v[(w + 1) % 4]; y = v[(w + 2) % 4]; z = v[(w + 3) % 4];
        k = i % 16;
        if (i < 16) begin
          f = z ^ (x & (y ^ z)); m = blk[k]; s = s1[i % 4];
        end else if (i < 32) begin
          f = (x & y) | (x & z) | (y & z); m = blk[ord2[k]] + K_ROUND2; s = s2[i % 4];
        end else begin
          f = x ^ y ^ z; m = blk[ord3[k]] + K_ROUND3; s = s3[i % 4];
        end
        v[w] = rol(v[w] + f + m, s);
      end
      for (int i = 0; i < 4; i++) chain[i] += v[i];
    endfunction

    function void put(int pos, logic [7:0] b);
      blk[pos / 4][(pos % 4) * 8 +: 8] = b;
    endfunction

    // note one accepted input transfer
    function void note_input(logic [7:0] b, logic has, logic fin);
      int pos;
      digest_res_t r;
      if (has) begin
        pos = nbits[8:3];
        put(pos, b);
        nbits += 64'd8;
        if (pos == 63) compress();
      end
      if (!fin) return;
      pos = nbits[8:3];
      put(pos, PAD_MARK);
      for (int i = pos + 1; i < 64; i++) put(i, 8'h00);
      if (pos >= 56) begin
        compress();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = nbits[31:0];
      blk[15] = nbits[63:32];
      compress();
      for (int i = 0; i < 4; i++) begin
        r.digest_word = chain[i];
        r.word_index = i[1:0];
        r.last_word = (i == 3);
        pending.push_back(r);
      end
      restart();
    endfunction

    function void check_result(logic [31:0] dw, logic [1:0] wi, logic lw);
      digest_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected digest word %h", dw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dw !== e.digest_word) begin
        $error("digest_word exp %h got %h", e.digest_word, dw); errors++;
      end
      if (wi !== e.word_index) begin
        $error("word_index exp %0d got %0d", e.word_index, wi); errors++;
      end
      if (lw !== e.last_word) begin
        $error("last_word exp %0d got %0d", e.last_word, lw); errors++;
      end
    endfunction
  endclass
endpackage

### test/md4_hash_engine_top_tb.sv
// Top-level testbench for md4_hash_engine_top: directed and random messages,
// bursty sender, stalling receiver. Depends on md4_pkg, md4_if, md4_tb_pkg and the RTL.
`timescale 1ns / 1ps
module md4_hash_engine_top_tb;
  import md4_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // watchdog bound on cycles without any transfer

  logic clk = 1'b0;
  logic rst = 1'b1;
  md4_in_if  in_ch ();
  md4_out_if out_ch ();
  md4_scoreboard digest_sb = new();

  bit long_hold = 0;   // receiver held off for a long stretch
  int idle_cycles = 0;

  md4_hash_engine_top i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_message = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Sampling of transfers at the edge: scoreboard sees values as they stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        digest_sb.note_input(in_ch.data_byte, in_ch.has_byte, in_ch.end_message);
      if (out_ch.valid && out_ch.ready)
        digest_sb.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: own stall pattern, with one long hold-off when asked
  initial begin
    int phase;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      phase = (phase + 1) % 64;
      if (phase < 20) out_ch.ready <= 1'b1;          // stretch with no stalls
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Sender burst counter; bursts of random length
  int burst_left = 0;

  // Offer one item and hold it until the transfer, with random gaps between bursts.
  task automatic send_item(logic [7:0] b, logic has, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte <= has;
    in_ch.end_message <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_message(int len, bit empty_fin);
    for (int i = 0; i < len; i++) begin
      if (!empty_fin && i == len - 1) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    if (empty_fin || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (digest_sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    int lens [5] = '{0, 55, 56, 63, 64};
    @(negedge rst);
    @(posedge clk);
    // Directed: empty message, idle items, short messages, byte extremes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    // Padding boundaries; receiver held off while the sender keeps going
    long_hold = 1;
    foreach (lens[i]) send_message(lens[i], 1'($urandom_range(0, 1)));
    drain();
    // Random: mostly short messages, occasional idle noise, a few long ones
    for (int n = 0; n < 12; n++) begin
      if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    drain();
    repeat (50) @(posedge clk);
    if (digest_sb.errors == 0 && digest_sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### sim.f
hdl/md4_pkg.sv
hdl/md4_if.sv
hdl/md4_ram.sv
hdl/md4_round.sv
hdl/md4_hash_engine_top.sv
test/md4_tb_pkg.sv
test/md4_hash_engine_top_tb.sv
